FILE: rtl/primitive_vertex_generator_core_macros.svh
// Assertion macros for the primitive vertex generator.
`ifndef PRIMITIVE_VERTEX_GENERATOR_CORE_MACROS_SVH
`define PRIMITIVE_VERTEX_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PVG_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("pvg assertion failed");
`define PVG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pvg assertion failed");
`else
`define PVG_ASSERT_NEVER(lbl, cond)
`define PVG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/pvg_pkg.sv
// Shared types, codes and elaboration-time factor functions of the vertex generator.
package pvg_pkg;

	localparam logic [2:0] CMD_QUAD    = 3'd0;
	localparam logic [2:0] CMD_ELLIPSE = 3'd1;
	localparam logic [2:0] CMD_SE4     = 3'd2;
	localparam logic [2:0] CMD_LINE    = 3'd3;
	localparam logic [2:0] CMD_SE16    = 3'd4;
	localparam logic [2:0] CMD_QBEZ    = 3'd5;
	localparam logic [2:0] CMD_CBEZ    = 3'd6;

	localparam logic [1:0] KIND_TRIS  = 2'd0;
	localparam logic [1:0] KIND_FAN   = 2'd1;
	localparam logic [1:0] KIND_LINES = 2'd2;
	localparam logic [1:0] KIND_STRIP = 2'd3;

	// factor table columns
	localparam int FAC_SIN    = 0;
	localparam int FAC_COS    = 1;
	localparam int FAC_R1COS  = 2;
	localparam int FAC_R1SIN  = 3;
	localparam int FAC_R3COS  = 4;
	localparam int FAC_R3SIN  = 5;
	localparam int FAC_COLS   = 6;

	localparam logic signed [15:0] Q14_POS = 16'sd16384;
	localparam logic signed [15:0] Q14_NEG = -16'sd16384;

	typedef struct packed {
		logic       v;
		logic [1:0] kind;
		logic       last;
		logic       bez;
		logic       cubic;
	} meta_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic longint unsigned quarter_sine(input longint unsigned z);
		longint unsigned z2, acc, r;
		if (z == 0) begin
			r = 0;
		end else if (z >= 64'd16384) begin
			r = 64'd16384;
		end else begin
			z2  = (z * z) << 2;
			acc = 64'd85569307 - ((z2 * 64'd5026994) >> 30);
			acc = 64'd693598673 - ((z2 * acc) >> 30);
			acc = 64'd1686629713 - ((z2 * acc) >> 30);
			r   = (z * acc + (64'd1 << 29)) >> 30;
			if (r > 64'd16384) begin
				r = 64'd16384;
			end
		end
		return r;
	endfunction

	function automatic longint phase_sine(input longint unsigned p);
		longint unsigned pm, q, r, m;
		pm = p & 64'hFFFF;
		q  = pm >> 14;
		r  = pm & 64'h3FFF;
		m  = q[0] ? quarter_sine(64'd16384 - r) : quarter_sine(r);
		return q[1] ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned res, bitv, vv;
		res  = 0;
		bitv = 64'd1 << 30;
		vv   = v;
		for (int k = 0; k < 16; k++) begin
			if (vv >= res + bitv) begin
				vv  = vv - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint root_factor(input longint v, input int times);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : longint'(v);
		for (int k = 0; k < times; k++) begin
			m = isqrt(m << 14);
		end
		return (v < 0) ? -longint'(m) : longint'(m);
	endfunction

	// Rim factor for one phase (1/65536 turn) and one column.
	function automatic logic signed [15:0] rim_factor(input longint unsigned ph, input int sel);
		longint sn, cs, f;
		sn = phase_sine(ph);
		cs = phase_sine(ph + 64'd16384);
		case (sel)
			FAC_SIN:   f = sn;
			FAC_COS:   f = cs;
			FAC_R1COS: f = root_factor(cs, 1);
			FAC_R1SIN: f = root_factor(sn, 1);
			FAC_R3COS: f = root_factor(cs, 3);
			default:   f = root_factor(sn, 3);
		endcase
		return f[15:0];
	endfunction

endpackage

FILE: rtl/primitive_vertex_generator_core.sv
// Top level of the primitive vertex generator: sequencer, factor table and vertex pipeline.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | cmd, center_*, size_*, ctrl3_*, ctrl4_*
//  out     | out_valid/out_stall| vertex_x, vertex_y, prim_kind, last_vertex
//
// A command of n vertices is taken when the sequencer is idle and holds the
// input while one vertex is issued per cycle by the sequencer counter, unless
// the output stalls. An unknown command is taken and emits nothing. Vertices pass
// the issue register, three lerp levels of three stages, the output register.
// Reset clears the sequencer and all valid bits. A stall on the output freezes
// the whole pipeline in place; nothing is dropped or issued twice.
module primitive_vertex_generator_core #(
	parameter int ELLIPSE_STEPS = 32,
	parameter int BEZIER_STEPS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [15:0] center_x,
	input  logic signed [15:0] center_y,
	input  logic signed [15:0] size_x,
	input  logic signed [15:0] size_y,
	input  logic signed [15:0] ctrl3_x,
	input  logic signed [15:0] ctrl3_y,
	input  logic signed [15:0] ctrl4_x,
	input  logic signed [15:0] ctrl4_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] vertex_x,
	output logic signed [15:0] vertex_y,
	output logic [1:0]         prim_kind,
	output logic               last_vertex
);

`include "primitive_vertex_generator_core_macros.svh"

	localparam int MAXA = (ELLIPSE_STEPS + 2 > BEZIER_STEPS) ? ELLIPSE_STEPS + 2 : BEZIER_STEPS;
	localparam int MAXC = (MAXA > 6) ? MAXA : 6;
	localparam int CW   = $clog2(MAXC);
	localparam int TW   = $clog2(ELLIPSE_STEPS);
	localparam int IW   = $clog2(BEZIER_STEPS);
	localparam int NST  = 10;

	localparam logic [7:0] QUAD_XPOS = 8'b0001_0110;
	localparam logic [7:0] QUAD_YPOS = 8'b0000_1011;

	// rim factor table, built at elaboration
	logic signed [15:0] fac_tab [0:pvg_pkg::FAC_COLS-1][0:ELLIPSE_STEPS-1];

	for (genvar t = 0; t < ELLIPSE_STEPS; t++) begin : g_rim
		localparam longint unsigned PH = (64'(t) * 64'd65536) / 64'(ELLIPSE_STEPS);
		for (genvar c = 0; c < pvg_pkg::FAC_COLS; c++) begin : g_col
			assign fac_tab[c][t] = pvg_pkg::rim_factor(PH, c);
		end
	end

	// command registers and sequencer
	logic [2:0]         cmd_q;
	logic signed [15:0] cx_q, cy_q, sx_q, sy_q, px_q, py_q, qx_q, qy_q;
	logic               busy_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      last_idx;
	logic               en, acc, issue, iss_last;
	logic [CW-1:0]      rim_raw;
	logic [TW-1:0]      rim_idx;

	pvg_pkg::meta_t     iss_meta;
	logic signed [15:0] iss_cx, iss_cy, iss_sx, iss_sy, iss_fx, iss_fy;

	logic               out_valid_q;

	// advance everything unless a finished vertex is held back
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = busy_q || !en;
	assign acc      = in_valid && !in_stall;
	assign issue    = busy_q && en;

	always_comb begin
		case (cmd_q)
			pvg_pkg::CMD_QUAD:  last_idx = CW'(5);
			pvg_pkg::CMD_LINE:  last_idx = CW'(1);
			pvg_pkg::CMD_QBEZ,
			pvg_pkg::CMD_CBEZ:  last_idx = CW'(BEZIER_STEPS - 1);
			default:            last_idx = CW'(ELLIPSE_STEPS + 1);
		endcase
	end

	assign iss_last = (idx_q == last_idx);
	assign rim_raw  = idx_q - CW'(1);
	assign rim_idx  = (rim_raw == CW'(ELLIPSE_STEPS)) ? TW'(0) : rim_raw[TW-1:0];

	// per-vertex operands: each axis is placed as c + round(s * f) saturated
	always_comb begin
		iss_meta       = '0;
		iss_meta.v     = issue;
		iss_meta.last  = iss_last;
		iss_cx = cx_q;
		iss_cy = cy_q;
		iss_sx = sx_q;
		iss_sy = sy_q;
		iss_fx = '0;
		iss_fy = '0;
		case (cmd_q)
			pvg_pkg::CMD_QUAD: begin
				iss_meta.kind = pvg_pkg::KIND_TRIS;
				iss_fx = QUAD_XPOS[idx_q[2:0]] ? pvg_pkg::Q14_POS : pvg_pkg::Q14_NEG;
				iss_fy = QUAD_YPOS[idx_q[2:0]] ? pvg_pkg::Q14_POS : pvg_pkg::Q14_NEG;
			end
			pvg_pkg::CMD_LINE: begin
				iss_meta.kind = pvg_pkg::KIND_LINES;
				if (idx_q != '0) begin
					iss_cx = sx_q;
					iss_cy = sy_q;
				end
			end
			pvg_pkg::CMD_ELLIPSE: begin
				iss_meta.kind = pvg_pkg::KIND_FAN;
				if (idx_q != '0) begin
					iss_fx = fac_tab[pvg_pkg::FAC_SIN][rim_idx];
					iss_fy = fac_tab[pvg_pkg::FAC_COS][rim_idx];
				end
			end
			pvg_pkg::CMD_SE4: begin
				iss_meta.kind = pvg_pkg::KIND_FAN;
				if (idx_q != '0) begin
					iss_fx = fac_tab[pvg_pkg::FAC_R1COS][rim_idx];
					iss_fy = fac_tab[pvg_pkg::FAC_R1SIN][rim_idx];
				end
			end
			pvg_pkg::CMD_SE16: begin
				iss_meta.kind = pvg_pkg::KIND_FAN;
				if (idx_q != '0) begin
					iss_fx = fac_tab[pvg_pkg::FAC_R3COS][rim_idx];
					iss_fy = fac_tab[pvg_pkg::FAC_R3SIN][rim_idx];
				end
			end
			pvg_pkg::CMD_QBEZ: begin
				iss_meta.kind = pvg_pkg::KIND_STRIP;
				iss_meta.bez  = 1'b1;
			end
			pvg_pkg::CMD_CBEZ: begin
				iss_meta.kind  = pvg_pkg::KIND_STRIP;
				iss_meta.bez   = 1'b1;
				iss_meta.cubic = 1'b1;
			end
			default: begin
				iss_meta.v = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (acc) begin
			busy_q <= (cmd != pvg_pkg::CMD_QBEZ + 3'd2);
			idx_q  <= '0;
		end else if (issue) begin
			// advance through the run, drop busy after the last vertex
			busy_q <= !iss_last;
			idx_q  <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= cmd;
			cx_q  <= center_x;
			cy_q  <= center_y;
			sx_q  <= size_x;
			sy_q  <= size_y;
			px_q  <= ctrl3_x;
			py_q  <= ctrl3_y;
			qx_q  <= ctrl4_x;
			qy_q  <= ctrl4_y;
		end
	end

	// stage 1: issue registers
	pvg_pkg::meta_t     meta_s [1:NST];
	logic signed [15:0] cx_s1, cy_s1, sx_s1, sy_s1, fx_s1, fy_s1;
	logic signed [15:0] b0x_s1, b0y_s1, b1x_s1, b1y_s1, b2x_s1, b2y_s1, b3x_s1, b3y_s1;
	logic [IW-1:0]      bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				meta_s[k] <= '0;
			end
		end else if (en) begin
			meta_s[1] <= iss_meta;
			for (int k = 2; k <= NST; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= iss_cx;
			cy_s1  <= iss_cy;
			sx_s1  <= iss_sx;
			sy_s1  <= iss_sy;
			fx_s1  <= iss_fx;
			fy_s1  <= iss_fy;
			b0x_s1 <= cx_q;
			b0y_s1 <= cy_q;
			b1x_s1 <= sx_q;
			b1y_s1 <= sy_q;
			b2x_s1 <= px_q;
			b2y_s1 <= py_q;
			b3x_s1 <= qx_q;
			b3y_s1 <= qy_q;
			bi_s1  <= idx_q[IW-1:0];
		end
	end

	// placement path: multiply, then round, add and saturate, then delay
	logic signed [31:0] prx_s2, pry_s2;
	logic signed [15:0] cx_s2, cy_s2;
	logic signed [15:0] side_x_s [3:NST];
	logic signed [15:0] side_y_s [3:NST];
	logic signed [31:0] rnd_x, rnd_y;

	assign rnd_x = prx_s2 + 32'sd8192;
	assign rnd_y = pry_s2 + 32'sd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s2 <= sx_s1 * fx_s1;
			pry_s2 <= sy_s1 * fy_s1;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			side_x_s[3] <= pvg_pkg::sat16({{2{cx_s2[15]}}, cx_s2} + rnd_x[31:14]);
			side_y_s[3] <= pvg_pkg::sat16({{2{cy_s2[15]}}, cy_s2} + rnd_y[31:14]);
			for (int k = 4; k <= NST; k++) begin
				side_x_s[k] <= side_x_s[k-1];
				side_y_s[k] <= side_y_s[k-1];
			end
		end
	end

	// de Casteljau: three lerp levels, quadratic reuses level two twice
	logic signed [15:0] ax, ay, bx, by, ex, ey, dx, dy, fx, fy, rx, ry, l3bx, l3by;
	logic [IW-1:0]      i_l1, i_l2;
	logic [IW-1:0]      i_u0, i_u1, i_u2, i_u3, i_u4, i_u5, i_u6, i_u7, i_u8, i_u9;

	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_ax (.clk, .en, .a(b0x_s1), .b(b1x_s1),
		.i(bi_s1), .res(ax), .i_out(i_l1));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_ay (.clk, .en, .a(b0y_s1), .b(b1y_s1),
		.i(bi_s1), .res(ay), .i_out(i_u0));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_bx (.clk, .en, .a(b1x_s1), .b(b2x_s1),
		.i(bi_s1), .res(bx), .i_out(i_u1));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_by (.clk, .en, .a(b1y_s1), .b(b2y_s1),
		.i(bi_s1), .res(by), .i_out(i_u2));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_ex (.clk, .en, .a(b2x_s1), .b(b3x_s1),
		.i(bi_s1), .res(ex), .i_out(i_u3));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_ey (.clk, .en, .a(b2y_s1), .b(b3y_s1),
		.i(bi_s1), .res(ey), .i_out(i_u4));

	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_dx (.clk, .en, .a(ax), .b(bx),
		.i(i_l1), .res(dx), .i_out(i_l2));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_dy (.clk, .en, .a(ay), .b(by),
		.i(i_l1), .res(dy), .i_out(i_u5));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_fx (.clk, .en, .a(bx), .b(ex),
		.i(i_l1), .res(fx), .i_out(i_u6));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_fy (.clk, .en, .a(by), .b(ey),
		.i(i_l1), .res(fy), .i_out(i_u7));

	// lerp(d, d) is d, so a quadratic passes through level three unchanged
	assign l3bx = meta_s[7].cubic ? fx : dx;
	assign l3by = meta_s[7].cubic ? fy : dy;

	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_rx (.clk, .en, .a(dx), .b(l3bx),
		.i(i_l2), .res(rx), .i_out(i_u8));
	pvg_lerp #(.BEZIER_STEPS(BEZIER_STEPS), .IW(IW)) u_ry (.clk, .en, .a(dy), .b(l3by),
		.i(i_l2), .res(ry), .i_out(i_u9));

	// output register
	logic signed [15:0] vx_q, vy_q;
	logic [1:0]         kind_q;
	logic               last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= meta_s[NST].v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_q   <= meta_s[NST].bez ? rx : side_x_s[NST];
			vy_q   <= meta_s[NST].bez ? ry : side_y_s[NST];
			kind_q <= meta_s[NST].kind;
			last_q <= meta_s[NST].last;
		end
	end

	assign out_valid   = out_valid_q;
	assign vertex_x    = vx_q;
	assign vertex_y    = vy_q;
	assign prim_kind   = kind_q;
	assign last_vertex = last_q;

	// an unknown command never starts a run
	`PVG_ASSERT_NEXT(a_unknown_idle, acc && (cmd == pvg_pkg::CMD_CBEZ + 3'd1), !busy_q)
	// a frozen pipeline does not move the sequencer
	`PVG_ASSERT_NEXT(a_hold_idx, busy_q && !en && !acc, $stable(idx_q))
	// Bezier vertices always leave as a line strip
	`PVG_ASSERT_NEVER(a_bez_kind, meta_s[NST].v && meta_s[NST].bez &&
		(meta_s[NST].kind != pvg_pkg::KIND_STRIP))

endmodule

FILE: rtl/pvg_lerp.sv
// Three-stage pipelined lerp a + round((b - a) * i / steps) for the Bezier datapath.
module pvg_lerp #(
	parameter int BEZIER_STEPS = 32,
	parameter int IW           = 5
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [15:0]   a,
	input  logic signed [15:0]   b,
	input  logic [IW-1:0]        i,
	output logic signed [15:0]   res,
	output logic [IW-1:0]        i_out
);

	localparam int PW = 17 + IW + 1;
	localparam longint unsigned DEN   = 64'(2 * BEZIER_STEPS);
	localparam longint unsigned BIASQ = 64'd1 << 23;
	localparam longint unsigned RECIP = (64'd1 << 32) / DEN;
	localparam logic [31:0] DEN32   = DEN[31:0];
	localparam logic [31:0] BIAS32  = 32'(BIASQ * DEN + 64'(BEZIER_STEPS));
	localparam logic [31:0] RECIP32 = RECIP[31:0];

	logic signed [PW-1:0] p_s1;
	logic signed [15:0]   a_s1, a_s2, res_s3;
	logic [IW-1:0]        i_s1, i_s2, i_s3;
	logic [31:0]          u_s2, q0_s2;
	logic signed [16:0]   diff;
	logic signed [PW-1:0] twop;
	logic [31:0]          u_nxt, r_c, q_c;
	logic [63:0]          m_c;
	logic [31:0]          qd_c;

	assign diff  = {b[15], b} - {a[15], a};
	assign twop  = p_s1 <<< 1;
	assign u_nxt = 32'(twop) + BIAS32;
	assign m_c   = u_nxt * 64'(RECIP32);
	assign qd_c  = q0_s2 * DEN32;
	assign r_c   = u_s2 - qd_c;
	assign q_c   = q0_s2 + ((r_c >= DEN32) ? 32'd1 : 32'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: difference times step index
			p_s1 <= PW'(diff * $signed({1'b0, i}));
			a_s1 <= a;
			i_s1 <= i;
			// stage 2: bias positive, multiply by reciprocal
			u_s2  <= u_nxt;
			q0_s2 <= m_c[63:32];
			a_s2  <= a_s1;
			i_s2  <= i_s1;
			// stage 3: correct the quotient by one, drop bias, add base
			res_s3 <= a_s2 + 16'(q_c - BIASQ[31:0]);
			i_s3   <= i_s2;
		end
	end

	assign res   = res_s3;
	assign i_out = i_s3;

endmodule
